// ----- design/scoped_symbol_binding_stack_macros.svh -----
// ----------------------------------------------------------------------------
// Scoped symbol binding stack: assertion macros
// Shared assertion wrappers, clocked on clk_i; SSBS_ASSERT is disabled while rst_ni is low (active-low reset).
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_BINDING_STACK_MACROS_SVH
`define SCOPED_SYMBOL_BINDING_STACK_MACROS_SVH

// Check a property outside reset
`define SSBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define SSBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/ssbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol binding stack package
// Widths, codes and the types passed between the top level and the cells.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned SYM_W           = 16;
  localparam int unsigned VAL_W           = 32;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_SCOPE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Shift request broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             lookup;
    logic             done;
    logic             found;
    logic [SYM_W-1:0] key;
    logic [SYM_W-1:0] end_key;
    logic [VAL_W-1:0] value;
  } token_t;

endpackage

// ----- design/ssbs_cell.sv -----
// ----------------------------------------------------------------------------
// Binding cell
// Holds one stack entry, shifts with its neighbours on push and pop, and
// tests the passing search token against its entry.
// ----------------------------------------------------------------------------
module ssbs_cell
  import ssbs_pkg::*;
#(
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shift_t           shift_i,
  input  logic [SYM_W-1:0] above_sym_i,
  input  logic [VAL_W-1:0] above_val_i,
  input  logic [SYM_W-1:0] below_sym_i,
  input  logic [VAL_W-1:0] below_val_i,
  output logic [SYM_W-1:0] sym_o,
  output logic [VAL_W-1:0] val_o,
  input  token_t           tok_i,
  input  logic [CNT_W-1:0] rem_i,
  output token_t           tok_o,
  output logic [CNT_W-1:0] rem_o
);

  logic [SYM_W-1:0] sym_q, sym_d;
  logic [VAL_W-1:0] val_q, val_d;
  token_t           tok_q, tok_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  // Take the entry from above on push, from below on pop
  always_comb begin
    sym_d = sym_q;
    val_d = val_q;
    if (shift_i.push) begin
      sym_d = above_sym_i;
      val_d = above_val_i;
    end else if (shift_i.pop) begin
      sym_d = below_sym_i;
      val_d = below_val_i;
    end
  end

  // Test the token: stop past the occupied entries or, on a scope check, at the
  // scope end; mark a match found (a lookup also captures its value), otherwise count one entry off
  always_comb begin
    tok_d = tok_i;
    rem_d = rem_i;
    if (tok_i.active && !tok_i.done) begin
      if (rem_i == '0) begin
        tok_d.done = 1'b1;
      end else if (!tok_i.lookup && (sym_q == tok_i.end_key)) begin
        tok_d.done = 1'b1;
      end else if (sym_q == tok_i.key) begin
        tok_d.done  = 1'b1;
        tok_d.found = 1'b1;
        if (tok_i.lookup) begin
          tok_d.value = val_q;
        end
      end else begin
        rem_d = rem_i - CNT_W'(1);
      end
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    val_q <= val_d;
  end

  // Advance the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      rem_q <= '0;
    end else begin
      tok_q <= tok_d;
      rem_q <= rem_d;
    end
  end

  assign sym_o = sym_q;
  assign val_o = val_q;
  assign tok_o = tok_q;
  assign rem_o = rem_q;

endmodule

// ----- design/scoped_symbol_binding_stack.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol binding stack
// A row of binding cells, newest on top; a search token walks the row.
// ----------------------------------------------------------------------------
// Push and pop: result registered, shown the cycle after the transfer; busy stays low.
// Lookup and scope check: result registered after the launch register and every cell, as
//   the token passes every cell once; busy stays high until the result shows.
// The result strobe done_o lasts one cycle; the receiver cannot stall.
// Reset empties the stack (count cleared); entries themselves are not cleared.
`include "scoped_symbol_binding_stack_macros.svh"

module scoped_symbol_binding_stack
  import ssbs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [SYM_W-1:0] symbol_id_i,
  input  logic [VAL_W-1:0] bound_value_i,
  input  logic [SYM_W-1:0] scope_end_symbol_i,
  output logic             done_o,
  output logic             found_o,
  output logic [VAL_W-1:0] found_value_o,
  output logic [SYM_W-1:0] popped_symbol_o,
  output logic [1:0]       status_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  token_t           launch_q, launch_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [VAL_W-1:0] fval_q, fval_d;
  logic [SYM_W-1:0] psym_q, psym_d;
  status_e          stat_q, stat_d;
  shift_t           shift;
  action_e          act;

  logic [SYM_W-1:0] sym_w [STACK_DEPTH];
  logic [VAL_W-1:0] val_w [STACK_DEPTH];
  token_t           tok_w [STACK_DEPTH+1];
  logic [CNT_W-1:0] rem_w [STACK_DEPTH+1];

  assign act      = action_e'(action_i);
  assign busy     = (state_q == ST_SEARCH);
  assign tok_w[0] = launch_q;
  assign rem_w[0] = rem_q;

  // Row of cells, cell 0 on top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] above_sym, below_sym;
    logic [VAL_W-1:0] above_val, below_val;

    if (i == 0) begin : g_top
      assign above_sym = symbol_id_i;
      assign above_val = bound_value_i;
    end else begin : g_mid
      assign above_sym = sym_w[i-1];
      assign above_val = val_w[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below_sym = sym_w[i];
      assign below_val = val_w[i];
    end else begin : g_inner
      assign below_sym = sym_w[i+1];
      assign below_val = val_w[i+1];
    end

    ssbs_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .above_sym_i (above_sym),
      .above_val_i (above_val),
      .below_sym_i (below_sym),
      .below_val_i (below_val),
      .sym_o       (sym_w[i]),
      .val_o       (val_w[i]),
      .tok_i       (tok_w[i]),
      .rem_i       (rem_w[i]),
      .tok_o       (tok_w[i+1]),
      .rem_o       (rem_w[i+1])
    );
  end

  // Decode the action, launch searches and collect results
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    shift           = '0;
    launch_d        = launch_q;
    launch_d.active = 1'b0;
    rem_d           = rem_q;
    done_d          = 1'b0;
    found_d         = 1'b0;
    fval_d          = '0;
    psym_d          = '0;
    stat_d          = STAT_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (act) inside
            ACT_PUSH: begin
              done_d = 1'b1;
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                stat_d = STAT_FULL;
              end else begin
                shift.push = 1'b1;
                count_d    = count_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              done_d = 1'b1;
              if (count_q == '0) begin
                stat_d = STAT_EMPTY;
              end else begin
                shift.pop = 1'b1;
                count_d   = count_q - CNT_W'(1);
                psym_d    = sym_w[0];
              end
            end
            ACT_LOOKUP, ACT_SCOPE: begin
              launch_d.active  = 1'b1;
              launch_d.lookup  = (act == ACT_LOOKUP);
              launch_d.done    = 1'b0;
              launch_d.found   = 1'b0;
              launch_d.key     = symbol_id_i;
              launch_d.end_key = scope_end_symbol_i;
              launch_d.value   = '0;
              rem_d            = count_q;
              state_d          = ST_SEARCH;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (tok_w[STACK_DEPTH].active) begin
          done_d  = 1'b1;
          found_d = tok_w[STACK_DEPTH].found;
          fval_d  = tok_w[STACK_DEPTH].value;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state and the launched token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      launch_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      launch_q <= launch_d;
    end
  end

  // Hold search count and result fields
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    found_q <= found_d;
    fval_q  <= fval_d;
    psym_q  <= psym_d;
    stat_q  <= stat_d;
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign found_value_o   = fval_q;
  assign popped_symbol_o = psym_q;
  assign status_o        = stat_q;

  `SSBS_ASSERT_ALWAYS(a_count_bound, rst_ni |-> (count_q <= CNT_W'(STACK_DEPTH)), "count overflow")
  `SSBS_ASSERT(a_stack_op_done, (start && !busy && !action_i[1]) |=> done_o, "push or pop lost its result")
  `SSBS_ASSERT(a_search_busy, (start && !busy && action_i[1]) |=> (busy && !done_o), "search not launched")
  `SSBS_ASSERT(a_full_hold, (done_o && (status_o == STAT_FULL)) |-> (count_q == CNT_W'(STACK_DEPTH)), "refused push changed the stack")
  `SSBS_ASSERT(a_token_single, tok_w[STACK_DEPTH].active |-> busy, "token out of a search")

endmodule
